// ===== rtl/cpd_pkg.sv =====
// ----------------------------------------------------------------------------
// cpd_pkg: shared types and constants of the cartesian to polar converter
// fixed-point formats, rotator angle steps, gain terms and angle codes
// ----------------------------------------------------------------------------
package cpd_pkg;

    // fraction bits of the rotator x and y
    localparam int unsigned XY_FRAC = 16;

    // angle accumulator: degrees * 2^16, signed
    localparam int unsigned ZW = 25;
    // clamped first-quadrant angle width
    localparam int unsigned AW = 23;

    localparam logic signed [ZW-1:0] QUARTER_Q16 = 25'sd5898240;
    localparam logic [ZW-1:0]        HALF_Q16    = 25'd11796480;
    localparam logic [ZW-1:0]        FULL_Q16    = 25'd23592960;
    localparam logic [ZW-1:0]        ROUND_HALF  = 25'd512;

    // output angle codes, 1/64 degree
    localparam logic [14:0] ANGLE_ZERO  = 15'd0;
    localparam logic [14:0] ANGLE_POS_Y = 15'd5760;
    localparam logic [14:0] ANGLE_NEG_Y = 15'd17280;
    localparam logic [14:0] ANGLE_FULL  = 15'd23040;

    // rotator gain correction, Q30
    localparam logic [63:0] GAIN_BASE_Q30 = 64'd652032874;
    localparam logic [63:0] GAIN_TAIL_Q30 = 64'd434688583;
    localparam int unsigned GAIN_W = 30;

    localparam logic [15:0] RADIUS_MAX = 16'hFFFF;

    // sign and zero flags of the input point
    typedef struct packed {
        logic x_neg;
        logic y_neg;
        logic x_zero;
        logic y_zero;
    } t_quad_flags;

    // atan(2^-i) in degrees * 2^16, rounded to nearest
    function automatic logic [21:0] step_angle(input int unsigned idx);
        logic [21:0] v;
        case (idx)
            0:       v = 22'd2949120;
            1:       v = 22'd1740967;
            2:       v = 22'd919879;
            3:       v = 22'd466945;
            4:       v = 22'd234379;
            5:       v = 22'd117304;
            6:       v = 22'd58666;
            7:       v = 22'd29335;
            8:       v = 22'd14668;
            9:       v = 22'd7334;
            10:      v = 22'd3667;
            11:      v = 22'd1833;
            12:      v = 22'd917;
            13:      v = 22'd458;
            14:      v = 22'd229;
            15:      v = 22'd115;
            16:      v = 22'd57;
            17:      v = 22'd29;
            18:      v = 22'd14;
            19:      v = 22'd7;
            20:      v = 22'd4;
            21:      v = 22'd2;
            22:      v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/cartesian_to_polar_degrees.sv =====
// ----------------------------------------------------------------------------
// cartesian_to_polar_degrees: pipelined cordic cartesian to polar converter
// radius rounded to an integer, angle in 1/64 degree in [0, 360)
// ----------------------------------------------------------------------------
// usage
//   slave channel: one point per transfer, x_coord and y_coord signed
//   master channel: one result per point, radius and angle_deg, in order
//   stages: one fold stage, one stage per rotation, three correction stages
//   throughput: one point per cycle while the master side takes results; every
//     stage is registered and the pipeline is fully streaming
//   each stage has its own valid bit and takes new data whenever it is empty
//     or its successor moves, so empty slots close up while the master side
//     is stalled and the slave side keeps accepting until the pipe is full
//   a stalled result holds on o_m_axis_tdata until the transfer completes
//   reset clears every valid bit; nothing else is kept between points
//   the origin gives radius 0 and angle 0; the y axis gives 90 or 270 degrees
// ----------------------------------------------------------------------------
module cartesian_to_polar_degrees
    import cpd_pkg::*;
#(
    parameter int unsigned COORD_WIDTH    = 16,
    parameter int unsigned ROTATION_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // x_coord[15:0], y_coord[31:16]
    // master side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata    // radius[15:0], angle_deg[30:16], zero[31]
);

    // rotator word: integer magnitude, fraction, and growth headroom
    localparam int unsigned XW = COORD_WIDTH + XY_FRAC + 3;
    localparam int unsigned N  = ROTATION_STEPS;

    // pipeline links between the rotation stages
    logic                 w_valid [0:N];
    logic                 w_ready [0:N];
    logic signed [XW-1:0] w_vx    [0:N];
    logic signed [XW-1:0] w_vy    [0:N];
    logic signed [ZW-1:0] w_z     [0:N];
    t_quad_flags          w_flags [0:N];

    logic [15:0] w_radius;
    logic [14:0] w_angle_deg;

    // fold to the first quadrant
    cpd_prep #(
        .CW (COORD_WIDTH),
        .XW (XW)
    ) u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_x_coord ($signed(i_s_axis_tdata[15:0])),
        .i_y_coord ($signed(i_s_axis_tdata[31:16])),
        .o_valid   (w_valid[0]),
        .i_ready   (w_ready[0]),
        .o_vx      (w_vx[0]),
        .o_vy      (w_vy[0]),
        .o_flags   (w_flags[0])
    );

    // angle accumulator starts at zero
    assign w_z[0] = '0;

    // one rotation per stage
    for (genvar g = 0; g < N; g++) begin : g_rot
        cpd_rot_stage #(
            .XW    (XW),
            .STAGE (g)
        ) u_rot (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_vx    (w_vx[g]),
            .i_vy    (w_vy[g]),
            .i_z     (w_z[g]),
            .i_flags (w_flags[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_vx    (w_vx[g+1]),
            .o_vy    (w_vy[g+1]),
            .o_z     (w_z[g+1]),
            .o_flags (w_flags[g+1])
        );
    end

    // gain correction, rounding and quadrant placement; the final y is unused
    cpd_post #(
        .CW    (COORD_WIDTH),
        .STEPS (N),
        .XW    (XW)
    ) u_post (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_valid[N]),
        .o_ready     (w_ready[N]),
        .i_vx        (w_vx[N]),
        .i_z         (w_z[N]),
        .i_flags     (w_flags[N]),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_radius    (w_radius),
        .o_angle_deg (w_angle_deg)
    );

    // pack the result, pad bit to make whole bytes
    assign o_m_axis_tdata = {1'b0, w_angle_deg, w_radius};

endmodule

// ===== rtl/cpd_prep.sv =====
// ----------------------------------------------------------------------------
// cpd_prep: input stage
// folds the point into the first quadrant and records its signs
// ----------------------------------------------------------------------------
module cpd_prep
    import cpd_pkg::*;
#(
    parameter int unsigned CW = 16,
    parameter int unsigned XW = CW + 19
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [15:0]   i_x_coord,
    input  logic signed [15:0]   i_y_coord,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [XW-1:0] o_vx,
    output logic signed [XW-1:0] o_vy,
    output t_quad_flags          o_flags
);

    logic [CW-1:0] w_x_raw, w_y_raw;
    logic [CW-1:0] w_x_mag, w_y_mag;
    logic          w_en;

    logic                 r_valid;
    logic signed [XW-1:0] r_vx, r_vy;
    t_quad_flags          r_flags;

    // field read in its low CW bits, sign taken from bit CW-1
    assign w_x_raw = CW'($unsigned(i_x_coord));
    assign w_y_raw = CW'($unsigned(i_y_coord));
    assign w_x_mag = w_x_raw[CW-1] ? (~w_x_raw + 1'b1) : w_x_raw;
    assign w_y_mag = w_y_raw[CW-1] ? (~w_y_raw + 1'b1) : w_y_raw;

    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_vx           <= XW'({w_x_mag, {XY_FRAC{1'b0}}});
            r_vy           <= XW'({w_y_mag, {XY_FRAC{1'b0}}});
            r_flags.x_neg  <= w_x_raw[CW-1];
            r_flags.y_neg  <= w_y_raw[CW-1];
            r_flags.x_zero <= (w_x_mag == '0);
            r_flags.y_zero <= (w_y_mag == '0);
        end
    end

    assign o_valid = r_valid;
    assign o_vx    = r_vx;
    assign o_vy    = r_vy;
    assign o_flags = r_flags;

endmodule

// ===== rtl/cpd_rot_stage.sv =====
// ----------------------------------------------------------------------------
// cpd_rot_stage: one vectoring rotation of the cordic pipeline
// drives y towards zero and accumulates the angle step
// ----------------------------------------------------------------------------
module cpd_rot_stage
    import cpd_pkg::*;
#(
    parameter int unsigned XW    = 35,
    parameter int unsigned STAGE = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [XW-1:0] i_vx,
    input  logic signed [XW-1:0] i_vy,
    input  logic signed [ZW-1:0] i_z,
    input  t_quad_flags          i_flags,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [XW-1:0] o_vx,
    output logic signed [XW-1:0] o_vy,
    output logic signed [ZW-1:0] o_z,
    output t_quad_flags          o_flags
);

    localparam logic signed [ZW-1:0] STEP = $signed(ZW'(step_angle(STAGE)));

    logic signed [XW-1:0] w_dx, w_dy;
    logic                 w_en;

    logic                 r_valid;
    logic signed [XW-1:0] r_vx, r_vy;
    logic signed [ZW-1:0] r_z;
    t_quad_flags          r_flags;

    assign w_dx    = i_vy >>> STAGE;
    assign w_dy    = i_vx >>> STAGE;
    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_flags <= i_flags;
            if (!i_vy[XW-1]) begin
                r_vx <= i_vx + w_dx;
                r_vy <= i_vy - w_dy;
                r_z  <= i_z + STEP;
            end else begin
                r_vx <= i_vx - w_dx;
                r_vy <= i_vy + w_dy;
                r_z  <= i_z - STEP;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_vx    = r_vx;
    assign o_vy    = r_vy;
    assign o_z     = r_z;
    assign o_flags = r_flags;

endmodule

// ===== rtl/cpd_post.sv =====
// ----------------------------------------------------------------------------
// cpd_post: gain correction and quadrant placement
// three stages: fraction product and clamp, integer product and quadrant,
// rounding with saturation and the axis cases
// ----------------------------------------------------------------------------
module cpd_post
    import cpd_pkg::*;
#(
    parameter int unsigned CW    = 16,
    parameter int unsigned STEPS = 16,
    parameter int unsigned XW    = CW + 19
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [XW-1:0] i_vx,
    input  logic signed [ZW-1:0] i_z,
    input  t_quad_flags          i_flags,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [15:0]          o_radius,
    output logic [14:0]          o_angle_deg
);

    localparam logic [63:0] GAIN_L = GAIN_BASE_Q30 +
        ((GAIN_TAIL_Q30 + (64'd1 << (2 * STEPS - 1))) >> (2 * STEPS));
    localparam logic [GAIN_W-1:0] GAIN = GAIN_W'(GAIN_L);

    localparam int unsigned IW = XW - XY_FRAC;        // integer part of vx
    localparam int unsigned LW = XY_FRAC + GAIN_W;    // fraction product
    localparam int unsigned PW = IW + GAIN_W + 1;     // full product
    localparam int unsigned SW = (PW + 1 > 47) ? PW + 1 : 47;

    logic w_en1, w_en2, w_en3;

    // stage 1
    logic [LW-1:0] w_lo;
    logic [AW-1:0] w_a;
    logic          r_v1;
    logic [IW-1:0] r1_int;
    logic [LW-1:0] r1_lo;
    logic [AW-1:0] r1_a;
    t_quad_flags   r1_flags;

    // stage 2
    logic [PW-1:0] w_prod;
    logic [ZW-1:0] w_full, w_rnd;
    logic          r_v2;
    logic [PW-1:0] r2_prod;
    logic [14:0]   r2_ang;
    t_quad_flags   r2_flags;

    // stage 3
    logic [SW-1:0]    w_rsum;
    logic [SW-31:0]   w_rint;
    logic [15:0]      w_radius;
    logic [14:0]      w_angle;
    logic             r_v3;
    logic [15:0]      r3_radius;
    logic [14:0]      r3_angle;

    assign w_en3   = !r_v3 || i_ready;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // first-quadrant angle clamped to [0, 90] degrees
    always_comb begin
        if (i_flags.y_zero || i_z[ZW-1]) begin
            w_a = '0;
        end else if (i_z > QUARTER_Q16) begin
            w_a = AW'(QUARTER_Q16);
        end else begin
            w_a = AW'(i_z);
        end
    end

    assign w_lo = LW'(i_vx[XY_FRAC-1:0]) * LW'(GAIN);

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_int   <= IW'($unsigned(i_vx[XW-1:XY_FRAC]));
            r1_lo    <= w_lo;
            r1_a     <= w_a;
            r1_flags <= i_flags;
        end
    end

    assign w_prod = PW'(r1_int) * PW'(GAIN) + PW'(r1_lo[LW-1:XY_FRAC]);

    always_comb begin
        case ({r1_flags.x_neg, r1_flags.y_neg})
            2'b00:   w_full = ZW'(r1_a);
            2'b01:   w_full = FULL_Q16 - ZW'(r1_a);
            2'b10:   w_full = HALF_Q16 - ZW'(r1_a);
            2'b11:   w_full = HALF_Q16 + ZW'(r1_a);
            default: w_full = '0;
        endcase
    end

    assign w_rnd = w_full + ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r2_prod  <= w_prod;
            r2_ang   <= w_rnd[ZW-1:10];
            r2_flags <= r1_flags;
        end
    end

    // radius: round the Q30 product and saturate to 16 bits
    assign w_rsum   = SW'(r2_prod) + (SW'(1) << 29);
    assign w_rint   = w_rsum[SW-1:30];
    assign w_radius = (|w_rint[SW-31:16]) ? RADIUS_MAX : w_rint[15:0];

    always_comb begin
        if (r2_flags.x_zero) begin
            if (r2_flags.y_zero) begin
                w_angle = ANGLE_ZERO;
            end else if (r2_flags.y_neg) begin
                w_angle = ANGLE_NEG_Y;
            end else begin
                w_angle = ANGLE_POS_Y;
            end
        end else if (r2_ang >= ANGLE_FULL) begin
            w_angle = r2_ang - ANGLE_FULL;
        end else begin
            w_angle = r2_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r3_radius <= w_radius;
            r3_angle  <= w_angle;
        end
    end

    assign o_valid     = r_v3;
    assign o_radius    = r3_radius;
    assign o_angle_deg = r3_angle;

endmodule

// ===== rtl/cpd_checker.sv =====
// ----------------------------------------------------------------------------
// cpd_checker: port-level checks of the cartesian to polar converter
// watches the stream ports only; attached to the top level by bind
// ----------------------------------------------------------------------------
module cpd_checker
    import cpd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [31:0] i_s_axis_tdata,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata
);

    // reset empties the pipeline
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // a stalled result holds
    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // angle wraps below a full turn, pad bit clear
    a_angle_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[30:16] < ANGLE_FULL) && !o_m_axis_tdata[31])
        else $error("angle out of range");

    // only the origin rounds to radius zero, and it has angle zero
    a_origin_angle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[15:0] == 16'd0) |->
            (o_m_axis_tdata[30:16] == ANGLE_ZERO))
        else $error("zero radius with nonzero angle");

endmodule

bind cartesian_to_polar_degrees cpd_checker u_cpd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for cartesian_to_polar_degrees
// streams signed points through the converter with random idling on both
// sides, predicts radius and angle with a bit-exact cordic model of its own
// and checks every result transfer in order against that prediction
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned COORD_BITS = 16;
    localparam int unsigned ROT_STEPS  = 16;
    // input transfer to output valid: fold, rotation and correction stages
    localparam int unsigned PIPE_LAT   = ROT_STEPS + 4;

    localparam int unsigned RANDOM_POINTS  = 1080;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned REPORT_LIMIT   = 10;
    // receiver hold-off that fills the pipe and stalls the slave side
    localparam int unsigned HOLD_AFTER     = 300;
    localparam int unsigned HOLD_CYCLES    = 150;

    // angle formats: degrees * 2^16 inside, 1/64 degree at the output
    localparam longint QUARTER_TURN_Q16 = 90 * 65536;
    localparam longint HALF_TURN_Q16    = 180 * 65536;
    localparam longint FULL_TURN_Q16    = 360 * 65536;
    localparam int unsigned OUT_SHIFT   = 10;

    localparam logic [14:0] DEG0_CODE      = 15'd0;
    localparam logic [14:0] DEG90_CODE     = 15'd5760;
    localparam logic [14:0] DEG270_CODE    = 15'd17280;
    localparam logic [14:0] FULL_TURN_CODE = 15'd23040;

    // rotator gain correction terms, q30
    localparam logic [63:0] GAIN_BASE = 64'd652032874;
    localparam logic [63:0] GAIN_TAIL = 64'd434688583;
    localparam logic [63:0] RADIUS_CAP = 64'd65535;

    // atan(2^-i) in degrees * 2^16, rounded to nearest
    localparam int unsigned ATAN_Q16 [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    // one input point, x in the low half of tdata
    typedef struct packed {
        logic signed [15:0] y;
        logic signed [15:0] x;
    } point_t;

    typedef struct packed {
        logic [15:0] radius;
        logic [14:0] angle;
    } polar_t;

    typedef struct {
        point_t pt;
        polar_t res;
    } polar_entry_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    point_t      i_s_axis_tdata = '0;     // x_coord[15:0], y_coord[31:16]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;          // radius[15:0], angle_deg[30:16], zero[31]

    point_t       pending_points[$];
    polar_entry_t expected_polar[$];

    int unsigned total_points = 0;
    int unsigned n_in = 0;
    int unsigned n_out = 0;
    int unsigned n_errors = 0;
    int unsigned idle_cycles = 0;
    int unsigned tx_gap = 0;
    int unsigned rx_gap = 0;
    int unsigned long_hold = 0;
    logic        long_hold_done = 1'b0;
    logic        s_xfer = 1'b0;

    cartesian_to_polar_degrees #(
        .COORD_WIDTH    (COORD_BITS),
        .ROTATION_STEPS (ROT_STEPS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // prediction: vectoring cordic on |x|, |y| in q16, then quadrant placement
    // ------------------------------------------------------------------------
    function automatic polar_t cordic_polar(input point_t p);
        logic [16:0]        ax, ay;
        logic signed [63:0] vx, vy, dx, dy, z, a, full;
        logic [63:0]        gain, prod, rad, ang;
        polar_t             r;
        ax = p.x[15] ? 17'h10000 - {1'b0, p.x} : {1'b0, p.x};
        ay = p.y[15] ? 17'h10000 - {1'b0, p.y} : {1'b0, p.y};
        vx = {31'b0, ax, 16'b0};
        vy = {31'b0, ay, 16'b0};
        z  = '0;
        for (int i = 0; i < ROT_STEPS; i++) begin
            // shifts floor toward minus infinity
            dx = vy >>> i;
            dy = vx >>> i;
            if (!vy[63]) begin
                vx = vx + dx;
                vy = vy - dy;
                z  = z + 64'(ATAN_Q16[i]);
            end else begin
                vx = vx - dx;
                vy = vy + dy;
                z  = z - 64'(ATAN_Q16[i]);
            end
        end
        // gain correction, integer and fraction parts multiplied apart
        gain = GAIN_BASE + ((GAIN_TAIL + (64'd1 << (2 * ROT_STEPS - 1))) >> (2 * ROT_STEPS));
        prod = (64'(vx) >> 16) * gain + (((64'(vx) & 64'hFFFF) * gain) >> 16);
        rad  = (prod + (64'd1 << 29)) >> 30;
        if (rad > RADIUS_CAP)
            rad = RADIUS_CAP;
        // first-quadrant angle, exact zero on the x axis, clamped
        a = z;
        if (ay == 0)
            a = 0;
        if (a < 0)
            a = 0;
        if (a > QUARTER_TURN_Q16)
            a = QUARTER_TURN_Q16;
        if (ax == 0) begin
            if (ay == 0)
                ang = 64'(DEG0_CODE);
            else if (p.y[15])
                ang = 64'(DEG270_CODE);
            else
                ang = 64'(DEG90_CODE);
        end else begin
            if (!p.x[15])
                full = p.y[15] ? FULL_TURN_Q16 - a : a;
            else
                full = p.y[15] ? HALF_TURN_Q16 + a : HALF_TURN_Q16 - a;
            ang = (64'(full) + (64'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;
            // rounding up to a full turn wraps to zero
            if (ang >= 64'(FULL_TURN_CODE))
                ang = ang - 64'(FULL_TURN_CODE);
        end
        r.radius = rad[15:0];
        r.angle  = ang[14:0];
        return r;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_extreme();
        logic [15:0] vals [7];
        vals = '{16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFE, 16'h7FFF};
        return vals[$urandom_range(0, 6)];
    endfunction

    // random point drawn from a mix of shapes
    function automatic point_t random_point();
        point_t      p;
        int unsigned kind;
        logic [15:0] v;
        kind = $urandom_range(0, 99);
        p    = point_t'($urandom());
        if (kind < 40) begin
            // whole range, every bit toggles
        end else if (kind < 55) begin
            p.x = 16'($urandom_range(0, 16) - 8);
            p.y = 16'($urandom_range(0, 16) - 8);
        end else if (kind < 65) begin
            if ($urandom_range(0, 1))
                p.x = '0;
            else
                p.y = '0;
        end else if (kind < 75) begin
            // just off an axis, including the wrap near a full turn
            if ($urandom_range(0, 1))
                p.x = 16'($urandom_range(0, 6) - 3);
            else
                p.y = 16'($urandom_range(0, 6) - 3);
        end else if (kind < 85) begin
            p.x = pick_extreme();
            p.y = pick_extreme();
        end else if (kind < 95) begin
            // close to the diagonals
            v   = 16'($urandom_range(0, 4) - 2);
            p.y = $urandom_range(0, 1) ? p.x + v : -p.x + v;
        end else begin
            p.x = 16'($urandom_range(0, 510) - 255);
            p.y = 16'($urandom_range(0, 510) - 255);
        end
        return p;
    endfunction

    task automatic add_point(input int x, input int y);
        point_t p;
        p.x = 16'(x);
        p.y = 16'(y);
        pending_points = {pending_points, p};
    endtask

    task automatic note_error(input string msg);
        n_errors++;
        if (n_errors <= REPORT_LIMIT)
            $display("error: %s", msg);
    endtask

    // ------------------------------------------------------------------------
    // slave side driver: new point after each transfer or gap, at negedge
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_points
        point_t nxt_pt;
        logic   nxt_v;
        logic   tx_no_idle;
        nxt_pt = i_s_axis_tdata;
        nxt_v  = i_s_axis_tvalid;
        // one stretch in four with no sender idling
        tx_no_idle = ((n_in / 128) % 4) == 1;
        if (!i_rst_n) begin
            nxt_v = 1'b0;
        end else if (!i_s_axis_tvalid || s_xfer) begin
            if (s_xfer && !tx_no_idle)
                tx_gap = pick_gap();
            if (tx_gap != 0) begin
                nxt_v  = 1'b0;
                tx_gap = tx_gap - 1;
            end else if (pending_points.size() != 0) begin
                nxt_pt = pending_points.pop_front();
                nxt_v  = 1'b1;
            end else begin
                nxt_v = 1'b0;
            end
        end
        i_s_axis_tvalid <= nxt_v;
        i_s_axis_tdata  <= nxt_pt;
    end

    // long receiver hold-off, counted on its own
    always @(negedge i_clk) begin
        if (long_hold != 0) begin
            long_hold <= long_hold - 1;
        end else if (!long_hold_done && n_in >= HOLD_AFTER) begin
            long_hold      <= HOLD_CYCLES;
            long_hold_done <= 1'b1;
        end
    end

    // master side ready with random stalls
    always @(negedge i_clk) begin : drive_ready
        logic        nxt_r;
        logic        rx_no_idle;
        int unsigned g;
        rx_no_idle = ((n_out / 128) % 4) == 2;
        nxt_r = 1'b1;
        if (!i_rst_n || long_hold != 0) begin
            nxt_r = 1'b0;
        end else if (rx_gap != 0) begin
            nxt_r  = 1'b0;
            rx_gap = rx_gap - 1;
        end else if (!rx_no_idle && $urandom_range(0, 99) < 25) begin
            g = pick_gap();
            if (g != 0) begin
                nxt_r  = 1'b0;
                rx_gap = g - 1;
            end
        end
        i_m_axis_tready <= nxt_r;
    end

    // ------------------------------------------------------------------------
    // monitor: predict on input transfer, check on output transfer
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_transfers
        polar_entry_t e;
        logic [15:0]  got_radius;
        logic [14:0]  got_angle;
        logic         got_pad;
        s_xfer <= i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            e.pt  = i_s_axis_tdata;
            e.res = cordic_polar(i_s_axis_tdata);
            expected_polar = {expected_polar, e};
            n_in <= n_in + 1;
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_radius = o_m_axis_tdata[15:0];
            got_angle  = o_m_axis_tdata[30:16];
            got_pad    = o_m_axis_tdata[31];
            n_out <= n_out + 1;
            if (expected_polar.size() == 0) begin
                note_error($sformatf("result with nothing expected: radius %0d angle %0d",
                                     got_radius, got_angle));
            end else begin
                e = expected_polar.pop_front();
                if (got_radius !== e.res.radius || got_angle !== e.res.angle
                        || got_pad !== 1'b0)
                    note_error($sformatf({"point x=%0d y=%0d: expected radius %0d angle %0d,",
                                          " got radius %0d angle %0d pad %b"},
                                         e.pt.x, e.pt.y, e.res.radius, e.res.angle,
                                         got_radius, got_angle, got_pad));
            end
        end
    end

    // watchdog: cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: %0d points in, %0d results out", n_in, n_out);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        // origin, axis ends and the four corners
        add_point(0, 0);
        add_point(32767, 0);
        add_point(-32768, 0);
        add_point(0, 32767);
        add_point(0, -32768);
        add_point(32767, 32767);
        add_point(-32768, 32767);
        add_point(-32768, -32768);
        add_point(32767, -32768);
        // unit steps around the origin
        add_point(1, 0);
        add_point(-1, 0);
        add_point(0, 1);
        add_point(0, -1);
        add_point(1, 1);
        add_point(-1, -1);
        add_point(1, -1);
        // near the x axis: just below a full turn wraps to zero, and either side of a half turn
        add_point(32767, -1);
        add_point(-32768, 1);
        add_point(-32768, -1);
        // one point per quadrant with easy radii
        add_point(3, 4);
        add_point(-5, 12);
        add_point(-100, -100);
        add_point(100, -100);
        for (int unsigned k = 0; k < RANDOM_POINTS; k++)
            pending_points = {pending_points, random_point()};
        total_points = pending_points.size();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_in < total_points || expected_polar.size() != 0)
            @(posedge i_clk);
        // stray results would show within the pipeline depth
        repeat (2 * PIPE_LAT) @(posedge i_clk);

        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
